// ===== rtl/ordered_array_list_assert.svh =====
// Assertion macros shared by the ordered array list RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ORDERED_ARRAY_LIST_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ASSERT_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define OLA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ordered array list check failed");

// A condition that must never be true outside reset.
`define OLA_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("ordered array list forbidden condition seen");

`else

`define OLA_ASSERT(lbl, clk, rstn, prop)
`define OLA_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== rtl/ola_pkg.sv =====
`default_nettype none

package ola_pkg;

  localparam int KEY_W  = 32;
  localparam int OP_W   = 2;
  localparam int POS_W  = 7;
  localparam int STAT_W = 2;
  localparam int FIDX_W = 6;
  localparam int ECNT_W = 7;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_SEARCH = 2'd2;
  localparam op_t OP_CLEAR  = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_RANGE    = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  // Per-cell command from the controller.
  typedef struct packed {
    logic cmp_en;   // compare the broadcast key against the stored entry
    logic ins_at;   // store the insert key here
    logic ins_up;   // take the lower neighbor's entry
    logic del_dn;   // take the upper neighbor's entry
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/ola_if.sv =====
`default_nettype none

interface ola_in_if;
  logic                        valid;
  logic                        ready;
  ola_pkg::op_t                op;
  logic signed [ola_pkg::KEY_W-1:0] key;
  logic [ola_pkg::POS_W-1:0]   position;

  modport source (output valid, output op, output key, output position, input ready);
  modport sink (input valid, input op, input key, input position, output ready);
endinterface

interface ola_out_if;
  logic                         valid;
  logic                         ready;
  ola_pkg::status_t             status;
  logic [ola_pkg::FIDX_W-1:0]   found_index;
  logic [ola_pkg::ECNT_W-1:0]   element_count;

  modport source (output valid, output status, output found_index, output element_count,
                  input ready);
  modport sink (input valid, input status, input found_index, input element_count,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/ola_cell.sv =====
`default_nettype none

`include "ordered_array_list_assert.svh"

module ola_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire ola_pkg::cell_cmd_t        cmd,
  input  wire logic                      valid,
  input  wire logic [ola_pkg::KEY_W-1:0] cmp_key,
  input  wire logic [ola_pkg::KEY_W-1:0] wr_key,
  input  wire logic [ola_pkg::KEY_W-1:0] left,
  input  wire logic [ola_pkg::KEY_W-1:0] right,
  output logic [ola_pkg::KEY_W-1:0]      entry,
  output logic                           match
);

  logic [ola_pkg::KEY_W-1:0] entry_r;
  logic                      match_r;

  // Only one shift direction is ever requested per item.
  always_ff @(posedge clk) begin
    if (cmd.del_dn) begin
      entry_r <= right;
    end else if (cmd.ins_up) begin
      entry_r <= left;
    end else if (cmd.ins_at) begin
      entry_r <= wr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (cmd.cmp_en) begin
      match_r <= valid && (entry_r == cmp_key);
    end
  end

  assign entry = entry_r;
  assign match = match_r;

  `OLA_ASSERT_NEVER(a_one_move, clk, rst_n, cmd.del_dn && (cmd.ins_up || cmd.ins_at))
  `OLA_ASSERT_NEVER(a_ins_exclusive, clk, rst_n, cmd.ins_up && cmd.ins_at)
  `OLA_ASSERT_NEVER(a_cmp_not_shift, clk, rst_n,
                    cmd.cmp_en && (cmd.del_dn || cmd.ins_up || cmd.ins_at))

endmodule

`default_nettype wire

// ===== rtl/ordered_array_list.sv =====
// Channel | Dir | Payload                              | Handshake
// in_chan | in  | op, key, position                    | valid/ready
// out_chan| out | status, found_index, element_count   | valid/ready
//
// When an item is accepted, every cell compares the key with its entry and
// registers the match; when the item fires, the first match is resolved and
// any shift of the row happens at once while the result is registered.
// An item cannot finish while the previous result sits in the output register
// and is not taken; the block then waits in S_EXEC and takes no new item.
// Reset (rst_n low, synchronous) empties the list; stored keys are not cleared.
`default_nettype none

`include "ordered_array_list_assert.svh"

module ordered_array_list #(
  parameter int CAPACITY = 64
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ola_in_if.sink    in_chan,
  ola_out_if.source out_chan
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int LOGS = $clog2(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                      state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  ola_pkg::op_t              op_r;
  logic [ola_pkg::KEY_W-1:0] key_r;
  logic [ola_pkg::POS_W-1:0] pos_r;

  logic [CAPACITY-1:0] valid_vec, match_vec, pre_vec, first_oh;
  logic [IW-1:0]       hit_idx;
  logic                any_hit, accept, fire, insert_ok, delete_ok;
  ola_pkg::status_t    status_nxt;
  logic [31:0]         found_wide, count_wide;

  logic                           out_valid_r;
  ola_pkg::status_t               status_r;
  logic [ola_pkg::FIDX_W-1:0]     fidx_r;
  logic [ola_pkg::ECNT_W-1:0]     ecnt_r;

  logic [ola_pkg::KEY_W-1:0] entry_vec [CAPACITY];
  ola_pkg::cell_cmd_t        cmd_vec   [CAPACITY];

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign fire          = (state_r == S_EXEC) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_chan.op;
      key_r <= in_chan.key;
      pos_r <= in_chan.position;
    end
  end

  // Prefix OR over the match bits marks every cell at or above the first match.
  always_comb begin
    logic [CAPACITY-1:0] p;
    p = match_vec;
    for (int s = 0; s < LOGS; s++) begin
      p = p | (p << (1 << s));
    end
    pre_vec = p;
  end

  assign first_oh = match_vec & ~(pre_vec << 1);
  assign any_hit  = |match_vec;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_oh[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  always_comb begin
    status_nxt = ola_pkg::ST_OK;
    count_nxt  = count_r;
    found_wide = '0;
    unique case (op_r) inside
      ola_pkg::OP_INSERT: begin
        if (32'(count_r) >= 32'(CAPACITY)) begin
          status_nxt = ola_pkg::ST_FULL;
        end else if (32'(pos_r) > 32'(count_r)) begin
          status_nxt = ola_pkg::ST_RANGE;
        end else begin
          count_nxt = CW'(count_r + 1'b1);
        end
      end
      ola_pkg::OP_DELETE, ola_pkg::OP_SEARCH: begin
        if (!any_hit) begin
          status_nxt = ola_pkg::ST_NOTFOUND;
        end else begin
          found_wide = 32'(hit_idx);
          if (op_r == ola_pkg::OP_DELETE) begin
            count_nxt = CW'(count_r - 1'b1);
          end
        end
      end
      ola_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      default: count_nxt = count_r;
    endcase
  end

  assign count_wide = 32'(count_nxt);
  assign insert_ok  = (op_r == ola_pkg::OP_INSERT) && (status_nxt == ola_pkg::ST_OK);
  assign delete_ok  = (op_r == ola_pkg::OP_DELETE) && any_hit;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ola_pkg::KEY_W-1:0] left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry_vec[i+1];
    end

    assign valid_vec[i]      = 32'(i) < 32'(count_r);
    assign cmd_vec[i].cmp_en = accept;
    assign cmd_vec[i].ins_at = fire && insert_ok && (32'(i) == 32'(pos_r));
    assign cmd_vec[i].ins_up = fire && insert_ok && (32'(i) > 32'(pos_r));
    assign cmd_vec[i].del_dn = fire && delete_ok && pre_vec[i];

    ola_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd_vec[i]),
      .valid   (valid_vec[i]),
      .cmp_key (in_chan.key),
      .wr_key  (key_r),
      .left    (left_w),
      .right   (right_w),
      .entry   (entry_vec[i]),
      .match   (match_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status_nxt;
      fidx_r   <= found_wide[ola_pkg::FIDX_W-1:0];
      ecnt_r   <= count_wide[ola_pkg::ECNT_W-1:0];
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = status_r;
  assign out_chan.found_index   = fidx_r;
  assign out_chan.element_count = ecnt_r;

  `OLA_ASSERT_NEVER(a_count_bound, clk, rst_n, 32'(count_r) > 32'(CAPACITY))
  `OLA_ASSERT(a_first_onehot, clk, rst_n, $onehot0(first_oh))
  `OLA_ASSERT(a_accept_exec, clk, rst_n, accept |=> (state_r == S_EXEC))
  `OLA_ASSERT(a_count_hold, clk, rst_n, !fire |=> $stable(count_r))
  `OLA_ASSERT(a_insert_grow, clk, rst_n,
              (fire && insert_ok) |=> (count_r == CW'($past(count_r) + 1'b1)))

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none

module tb_top;

  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 1460;
  localparam int MODE_SPAN    = 150;
  localparam int CALM_ITEMS   = 100;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 8;

  typedef logic signed [ola_pkg::KEY_W-1:0] key_t;
  typedef logic [ola_pkg::POS_W-1:0]        pos_t;
  typedef logic [ola_pkg::FIDX_W-1:0]       fidx_t;
  typedef logic [ola_pkg::ECNT_W-1:0]       ecnt_t;

  localparam key_t KEY_MIN = 32'sh8000_0000;
  localparam key_t KEY_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    ola_pkg::status_t status;
    fidx_t            found_index;
    ecnt_t            element_count;
  } list_result_t;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} traffic_mode_t;

  // Tracks the list contents and the results that are still owed by the block.
  class list_scoreboard;
    key_t         entries[$];
    list_result_t owed[$];
    int           errors;
    int           requests;
    int           checked;
    int           peak_count;
    int           status_seen[4];

    function void note_request(ola_pkg::op_t op, key_t key, pos_t pos);
      list_result_t want;
      int           hit;
      want = '0;
      hit  = -1;
      case (op)
        ola_pkg::OP_INSERT: begin
          if (entries.size() >= LIST_DEPTH) begin
            want.status = ola_pkg::ST_FULL;
          end else if (int'(pos) > entries.size()) begin
            want.status = ola_pkg::ST_RANGE;
          end else begin
            entries.insert(int'(pos), key);
          end
        end
        ola_pkg::OP_DELETE, ola_pkg::OP_SEARCH: begin
          foreach (entries[i]) begin
            if (hit < 0 && entries[i] === key) hit = i;
          end
          if (hit < 0) begin
            want.status = ola_pkg::ST_NOTFOUND;
          end else begin
            want.found_index = fidx_t'(hit);
            if (op == ola_pkg::OP_DELETE) entries.delete(hit);
          end
        end
        default: begin
          // Clear only drops the count; the stale keys are never matched again.
          entries.delete();
        end
      endcase
      want.element_count = ecnt_t'(entries.size());
      if (entries.size() > peak_count) peak_count = entries.size();
      status_seen[want.status]++;
      requests++;
      owed.push_back(want);
    endfunction

    function void check_result(ola_pkg::status_t status, fidx_t found_index,
                               ecnt_t element_count);
      list_result_t want;
      if (owed.size() == 0) begin
        $error("unexpected result: status %0d found_index %0d element_count %0d",
               status, found_index, element_count);
        errors++;
        return;
      end
      want = owed.pop_front();
      checked++;
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (found_index !== want.found_index) begin
        $error("found_index: expected %0d, got %0d", want.found_index, found_index);
        errors++;
      end
      if (element_count !== want.element_count) begin
        $error("element_count: expected %0d, got %0d", want.element_count, element_count);
        errors++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  bit   stall_on;
  int   quiet_cycles;

  list_scoreboard sb = new();

  ola_in_if  in_chan();
  ola_out_if out_chan();

  ordered_array_list #(.CAPACITY(LIST_DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Present one item and hold it until the block takes it.
  task automatic send_request(input ola_pkg::op_t op, input key_t key, input pos_t pos);
    in_chan.valid    <= 1'b1;
    in_chan.op       <= op;
    in_chan.key      <= key;
    in_chan.position <= pos;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_request(op, key, pos);
  endtask

  task automatic idle_sender(input int cycles);
    in_chan.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off the sender until every outstanding result has been returned.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic key_t pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && sb.entries.size() > 0) return sb.entries[$urandom_range(0, sb.entries.size() - 1)];
    if (r < 70) return key_t'($urandom_range(0, 6)) - key_t'(3);
    if (r < 75) return r[0] ? KEY_MIN : KEY_MAX;
    return key_t'($urandom());
  endfunction

  function automatic pos_t pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return pos_t'($urandom_range(0, sb.entries.size()));
    if (r < 95) return pos_t'($urandom_range(sb.entries.size() + 1, 127));
    return pos_t'($urandom_range(0, 127));
  endfunction

  function automatic ola_pkg::op_t pick_op(traffic_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW:   return r < 70 ? ola_pkg::OP_INSERT : r < 80 ? ola_pkg::OP_DELETE :
                          r < 99 ? ola_pkg::OP_SEARCH : ola_pkg::OP_CLEAR;
      MODE_SHRINK: return r < 20 ? ola_pkg::OP_INSERT : r < 75 ? ola_pkg::OP_DELETE :
                          r < 98 ? ola_pkg::OP_SEARCH : ola_pkg::OP_CLEAR;
      default:     return r < 40 ? ola_pkg::OP_INSERT : r < 65 ? ola_pkg::OP_DELETE :
                          r < 98 ? ola_pkg::OP_SEARCH : ola_pkg::OP_CLEAR;
    endcase
  endfunction

  initial begin
    traffic_mode_t mode;
    int            gap_pct;
    rst_n            <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.op       <= ola_pkg::OP_CLEAR;
    in_chan.key      <= '0;
    in_chan.position <= '0;
    calm             = 1'b0;
    stall_on         = 1'b1;
    gap_pct          = 20;
    mode             = MODE_GROW;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list corner cases.
    send_request(ola_pkg::OP_CLEAR,  '0,      7'd0);
    send_request(ola_pkg::OP_SEARCH, '0,      7'd0);
    send_request(ola_pkg::OP_DELETE, -32'sd1, 7'd0);
    send_request(ola_pkg::OP_INSERT, 32'sd7,  7'd1);
    send_request(ola_pkg::OP_INSERT, 32'sd7,  7'd127);
    // Build [-1, min, -1, max, 0] with inserts at the head, the tail and the middle.
    send_request(ola_pkg::OP_INSERT, KEY_MIN, 7'd0);
    send_request(ola_pkg::OP_INSERT, KEY_MAX, 7'd1);
    send_request(ola_pkg::OP_INSERT, -32'sd1, 7'd0);
    send_request(ola_pkg::OP_INSERT, '0,      7'd3);
    send_request(ola_pkg::OP_INSERT, -32'sd1, 7'd2);
    send_request(ola_pkg::OP_SEARCH, -32'sd1, 7'd0);
    send_request(ola_pkg::OP_SEARCH, KEY_MAX, 7'd0);
    send_request(ola_pkg::OP_SEARCH, '0,      7'd0);
    send_request(ola_pkg::OP_SEARCH, 32'sd12345, 7'd0);
    send_request(ola_pkg::OP_DELETE, -32'sd1, 7'd0);
    send_request(ola_pkg::OP_SEARCH, -32'sd1, 7'd0);
    send_request(ola_pkg::OP_DELETE, '0,      7'd0);
    send_request(ola_pkg::OP_DELETE, KEY_MIN, 7'd0);
    send_request(ola_pkg::OP_INSERT, 32'sd9,  7'd3);
    send_request(ola_pkg::OP_CLEAR,  KEY_MAX, 7'd127);
    // Keys left behind by the clear must not match.
    send_request(ola_pkg::OP_SEARCH, KEY_MAX, 7'd0);
    send_request(ola_pkg::OP_INSERT, 32'sd5,  7'd0);
    drain_results();

    // Fill to capacity, then hit the full case, with a bad position too.
    while (sb.entries.size() < LIST_DEPTH) begin
      if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 11));
      send_request(ola_pkg::OP_INSERT, pick_key(),
                   pos_t'($urandom_range(0, sb.entries.size())));
    end
    send_request(ola_pkg::OP_INSERT, pick_key(), 7'd127);
    send_request(ola_pkg::OP_INSERT, pick_key(), 7'd64);
    send_request(ola_pkg::OP_INSERT, pick_key(), 7'd0);
    send_request(ola_pkg::OP_SEARCH, sb.entries[LIST_DEPTH-1], 7'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % MODE_SPAN == 0) begin
        drain_results();
        mode     = traffic_mode_t'((i / MODE_SPAN) % 3);
        gap_pct  = 10 * $urandom_range(0, 3);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (!calm && $urandom_range(0, 99) < gap_pct) idle_sender($urandom_range(1, 11));
      send_request(pick_op(mode), pick_key(), pick_position());
    end

    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d results for %0d requests: %0d ok, %0d full, %0d bad position, %0d not found.",
             sb.checked, sb.requests, sb.status_seen[ola_pkg::ST_OK],
             sb.status_seen[ola_pkg::ST_FULL], sb.status_seen[ola_pkg::ST_RANGE],
             sb.status_seen[ola_pkg::ST_NOTFOUND]);
    $display("The list peaked at %0d entries under random gaps and output stalls.", sb.peak_count);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Output side: ready drops for random bursts unless stalls are off for this span or the run is in its calm tail.
  initial begin
    out_chan.ready <= 1'b0;
    repeat (5) @(posedge clk);
    forever begin
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      if (!calm && stall_on) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      sb.check_result(out_chan.status, out_chan.found_index, out_chan.element_count);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles without a handshake.", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire
